>>> sv/fps_pkg.sv
package fps_pkg;

   // One result of the scanner, field widths as seen on the result port.
   typedef struct packed {
      logic [15:0] center_col_q3;
      logic [11:0] row_number;
      logic [12:0] run_outer_left;
      logic [12:0] run_inner_left;
      logic [12:0] run_core;
      logic [12:0] run_inner_right;
      logic [12:0] run_outer_right;
      logic [12:0] pattern_width;
      logic        found_at_row_end;
   } rsp_type;

   localparam int RSP_QUEUE_DEPTH = 3;
   localparam int RSP_PTR_W       = $clog2(RSP_QUEUE_DEPTH);
   localparam int RSP_CNT_W       = $clog2(RSP_QUEUE_DEPTH + 1);

   localparam logic [2:0] PHASE_FIRST = 3'd0;
   localparam logic [2:0] PHASE_LAST  = 3'd4;
   localparam logic [2:0] PHASE_SHIFTED = 3'd3;

   localparam logic [3:0] TOLERANCE_RESET = 4'd8;

endpackage

>>> sv/fps_eval.sv
module fps_eval #(
   parameter int CW = 13
) (
   input  logic [4:0][CW-1:0] runs,
   input  logic [CW-1:0]      end_col,
   input  logic [11:0]        row,
   input  logic [3:0]         tol,
   input  logic               at_row_end,
   output logic               hit,
   output fps_pkg::rsp_type   rsp
);

   localparam int EW = CW + 10;
   localparam int XW = CW + 17;

   logic [EW-1:0]        total;
   logic [EW-1:0]        lim;
   logic [4:0][EW-1:0]   ref_val;
   logic [4:0][EW-1:0]   run_x7;
   logic [4:0][EW-1:0]   dev;
   logic [4:0][EW-1:0]   bound;
   logic [4:0]           run_ok;
   logic [4:0][CW+12:0]  runs_ext;
   logic [XW-1:0]        end_x8;
   logic [XW-1:0]        weight;
   logic [XW-1:0]        center_diff;
   logic [15:0]          center;
   logic [12:0]          total_sat;

   assign total = EW'(runs[0]) + EW'(runs[1]) + EW'(runs[2]) + EW'(runs[3]) + EW'(runs[4]);
   assign lim   = total * EW'(tol);

   // Each run is compared against its ideal share of the total: one module for
   // each of the other four runs, three modules for the core, all scaled by 7 to stay integer.
   always_comb begin
      for (int k = 0; k < 5; k++) begin
         run_x7[k] = EW'(runs[k]) * EW'(7);
         if (k == 2) begin
            ref_val[k] = total * EW'(3);
            bound[k]   = lim * EW'(3);
         end else begin
            ref_val[k] = total;
            bound[k]   = lim;
         end
         dev[k]      = (ref_val[k] > run_x7[k]) ? (ref_val[k] - run_x7[k])
                                                : (run_x7[k] - ref_val[k]);
         run_ok[k]   = (dev[k] << 4) < bound[k];
         runs_ext[k] = {13'd0, runs[k]};
      end
   end

   assign hit = (total >= EW'(7)) && (&run_ok);

   assign end_x8 = XW'(end_col) << 3;
   assign weight = XW'(runs[4]) * XW'(7) + XW'(runs[3]) * XW'(6) + XW'(runs[2]) * XW'(4)
                 + XW'(runs[1]) * XW'(2) + XW'(runs[0]);
   assign center_diff = end_x8 - weight;

   always_comb begin
      if (end_x8 < weight) begin
         center = 16'd0;
      end else if (center_diff > XW'(65535)) begin
         center = 16'hFFFF;
      end else begin
         center = center_diff[15:0];
      end
   end

   assign total_sat = (total < EW'(8191)) ? total[12:0] : 13'h1FFF;

   always_comb begin
      rsp.center_col_q3    = center;
      rsp.row_number       = row;
      rsp.run_outer_left   = runs_ext[0][12:0];
      rsp.run_inner_left   = runs_ext[1][12:0];
      rsp.run_core         = runs_ext[2][12:0];
      rsp.run_inner_right  = runs_ext[3][12:0];
      rsp.run_outer_right  = runs_ext[4][12:0];
      rsp.pattern_width    = total_sat;
      rsp.found_at_row_end = at_row_end;
   end

endmodule

>>> sv/fps_rsp_queue.sv
module fps_rsp_queue (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  fps_pkg::rsp_type                 push_data,
   input  logic                             pop,
   output fps_pkg::rsp_type                 head,
   output logic [fps_pkg::RSP_CNT_W-1:0]    count
);

   fps_pkg::rsp_type                    entries_ff [fps_pkg::RSP_QUEUE_DEPTH];
   logic [fps_pkg::RSP_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [fps_pkg::RSP_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [fps_pkg::RSP_CNT_W-1:0]       count_ff, count_in;

   localparam logic [fps_pkg::RSP_PTR_W-1:0] PTR_TOP =
      fps_pkg::RSP_PTR_W'(fps_pkg::RSP_QUEUE_DEPTH - 1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_TOP) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_TOP) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head  = entries_ff[rd_ptr_ff];
   assign count = count_ff;

endmodule

>>> sv/finder_pattern_row_scanner.sv
// Finder pattern row scanner.
// The req channel carries one binarized pixel per transfer (req_pixel_dark,
// req_row_last), row by row in raster order. The rsp channel carries one
// candidate per transfer: the centre column in eighths of a pixel, the row,
// the five run lengths and their total. The csr channel writes the ratio
// tolerance in sixteenths of a module; csr_ready is always high and a write
// takes effect for the next pixel processed.
// Throughput is one pixel per cycle while req is not stalled. A pixel is held
// in an input register and then the run update and both ratio tests are done
// in a single pass, so a result enters the output queue in the cycle after its
// pixel transfer and is presented on rsp once it reaches the queue head.
// Results wait in a three-entry queue. The block stalls req only when the
// queue plus the pixel in flight could overflow it, so a stalled rsp channel
// holds its payload while pixels keep flowing until results pile up.
// Reset clears the run counts, column and row counters and the queue, and sets
// the tolerance to 8 (half a module). No clearing pass follows reset.
module finder_pattern_row_scanner #(
   parameter int MAX_ROW_WIDTH = 4096,
   parameter int MAX_ROWS      = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_pixel_dark,
   input  logic        req_row_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_center_col_q3,
   output logic [11:0] rsp_row_number,
   output logic [12:0] rsp_run_outer_left,
   output logic [12:0] rsp_run_inner_left,
   output logic [12:0] rsp_run_core,
   output logic [12:0] rsp_run_inner_right,
   output logic [12:0] rsp_run_outer_right,
   output logic [12:0] rsp_pattern_width,
   output logic        rsp_found_at_row_end,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_ratio_tolerance_q4
);

   localparam int CW  = $clog2(MAX_ROW_WIDTH + 1);
   localparam int RWD = $clog2(MAX_ROWS);
   localparam logic [CW-1:0]  RUN_MAX  = CW'(MAX_ROW_WIDTH);
   localparam logic [RWD-1:0] ROW_LAST = RWD'(MAX_ROWS - 1);

   logic                  pend_valid_ff, pend_valid_in;
   logic                  pend_dark_ff;
   logic                  pend_last_ff;
   logic [3:0]            tol_ff;
   logic [4:0][CW-1:0]    runs_ff, runs_in, runs_step;
   logic [2:0]            phase_ff, phase_in, phase_step, phase_cur;
   logic [CW-1:0]         col_ff, col_in, col_step;
   logic [RWD-1:0]        row_ff, row_in;
   logic [RWD+11:0]       row_ext;
   logic                  mid_test;
   logic                  mid_match, end_match;
   logic                  mid_hit, end_hit;
   fps_pkg::rsp_type      mid_rsp, end_rsp, push_data, head;
   logic                  push, pop;
   logic [fps_pkg::RSP_CNT_W-1:0] count;
   logic [fps_pkg::RSP_CNT_W:0]   occupancy;

   assign occupancy     = {1'b0, count} + (fps_pkg::RSP_CNT_W + 1)'(pend_valid_ff);
   assign req_stall     = occupancy >= (fps_pkg::RSP_CNT_W + 1)'(fps_pkg::RSP_QUEUE_DEPTH);
   assign pend_valid_in = req_valid && !req_stall;
   assign csr_ready     = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_valid_in) begin
         pend_dark_ff <= req_pixel_dark;
         pend_last_ff <= req_row_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= fps_pkg::TOLERANCE_RESET;
      end else if (csr_valid && csr_ready) begin
         tol_ff <= csr_ratio_tolerance_q4;
      end
   end

   // Run update for one pixel. Odd phases count white, even phases count black.
   always_comb begin
      phase_cur  = (phase_ff > fps_pkg::PHASE_LAST) ? fps_pkg::PHASE_LAST : phase_ff;
      runs_step  = runs_ff;
      phase_step = phase_cur;
      mid_test   = 1'b0;
      if (pend_dark_ff) begin
         if (phase_cur[0]) begin
            phase_step = phase_cur + 3'd1;
         end
      end else if (!phase_cur[0]) begin
         if (phase_cur == fps_pkg::PHASE_LAST) begin
            mid_test = 1'b1;
         end else begin
            phase_step = phase_cur + 3'd1;
         end
      end
      if (mid_test) begin
         // The fifth run has ended: drop the first two runs and keep counting white.
         runs_step[0] = runs_ff[2];
         runs_step[1] = runs_ff[3];
         runs_step[2] = runs_ff[4];
         runs_step[3] = CW'(1);
         runs_step[4] = '0;
         phase_step   = fps_pkg::PHASE_SHIFTED;
      end else begin
         for (int k = 0; k < 5; k++) begin
            if (phase_step == 3'(k) && runs_ff[k] < RUN_MAX) begin
               runs_step[k] = runs_ff[k] + 1'b1;
            end
         end
      end
      col_step = (col_ff < RUN_MAX) ? col_ff + 1'b1 : col_ff;
   end

   assign row_ext = {12'd0, row_ff};

   fps_eval #(.CW(CW)) u_mid_eval (
      .runs       (runs_ff),
      .end_col    (col_ff),
      .row        (row_ext[11:0]),
      .tol        (tol_ff),
      .at_row_end (1'b0),
      .hit        (mid_match),
      .rsp        (mid_rsp)
   );

   fps_eval #(.CW(CW)) u_end_eval (
      .runs       (runs_step),
      .end_col    (col_step),
      .row        (row_ext[11:0]),
      .tol        (tol_ff),
      .at_row_end (1'b1),
      .hit        (end_match),
      .rsp        (end_rsp)
   );

   // A mid-row match wins; a row-end match is only pushed when it did not fire.
   assign mid_hit   = pend_valid_ff && mid_test && mid_match;
   assign end_hit   = pend_valid_ff && pend_last_ff && !mid_hit && end_match;
   assign push      = mid_hit || end_hit;
   assign push_data = mid_hit ? mid_rsp : end_rsp;

   always_comb begin
      runs_in  = runs_ff;
      phase_in = phase_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      if (pend_valid_ff) begin
         if (pend_last_ff) begin
            runs_in  = '0;
            phase_in = fps_pkg::PHASE_FIRST;
            col_in   = '0;
            row_in   = (row_ff == ROW_LAST) ? '0 : row_ff + 1'b1;
         end else begin
            runs_in  = runs_step;
            phase_in = phase_step;
            col_in   = col_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         runs_ff  <= '0;
         phase_ff <= fps_pkg::PHASE_FIRST;
         col_ff   <= '0;
         row_ff   <= '0;
      end else begin
         runs_ff  <= runs_in;
         phase_ff <= phase_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
      end
   end

   fps_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .count     (count)
   );

   assign rsp_valid            = (count != '0);
   assign pop                  = rsp_valid && !rsp_stall;
   assign rsp_center_col_q3    = head.center_col_q3;
   assign rsp_row_number       = head.row_number;
   assign rsp_run_outer_left   = head.run_outer_left;
   assign rsp_run_inner_left   = head.run_inner_left;
   assign rsp_run_core         = head.run_core;
   assign rsp_run_inner_right  = head.run_inner_right;
   assign rsp_run_outer_right  = head.run_outer_right;
   assign rsp_pattern_width    = head.pattern_width;
   assign rsp_found_at_row_end = head.found_at_row_end;

`ifndef SYNTHESIS
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && count == fps_pkg::RSP_CNT_W'(fps_pkg::RSP_QUEUE_DEPTH)) |-> pop)
      else $error("result queue overflow");

   a_mid_hit_on_white: assert property (@(posedge clock) disable iff (reset)
      mid_hit |-> !pend_dark_ff)
      else $error("mid-row match on a dark pixel");

   a_row_end_clears: assert property (@(posedge clock) disable iff (reset)
      (pend_valid_ff && pend_last_ff) |=> (phase_ff == fps_pkg::PHASE_FIRST && col_ff == '0))
      else $error("run state not cleared at row end");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= fps_pkg::PHASE_LAST)
      else $error("run phase out of range");
`endif

endmodule
